// ----- rtl/mia_pkg.sv -----
// Shared types and constants of the adjugate matrix inverter.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package mia_pkg;

  // Default largest matrix order.
  localparam int MAX_ORDER_DEF = 4;

  // Field widths.
  localparam int ORDER_W = 3;
  localparam int ELEM_W  = 16;
  localparam int INV_W   = 32;
  localparam int DETQ_W  = 64;

  // Order after reset.
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  // Fraction bits of the input elements and of the quantized determinant.
  localparam int ELEM_FRAC = 8;
  localparam int DETQ_FRAC = 24;

  // The numerator is scaled by 2^25 and divided by twice the determinant,
  // which rounds adj * 2^24 / det to nearest.
  localparam int DIV_SHIFT = 25;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DET_INIT,
    S_TUPLE,
    S_FETCH,
    S_MUL_LOAD,
    S_MUL,
    S_ACCUM,
    S_NEXT,
    S_ENUM_DONE,
    S_DET_CHECK,
    S_COF_INIT,
    S_DIV,
    S_EMIT,
    S_SING
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic enum_init;
    logic enum_cof;
    logic enum_next;
    logic term_start;
    logic row_step;
    logic mul_load;
    logic mul_step;
    logic accum;
    logic det_latch;
    logic det_quant;
    logic div_init;
    logic div_step;
    logic emit;
    logic emit_sing;
    logic pos_next;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_done;
    logic tuple_ok;
    logic enum_wrap;
    logic row_end;
    logic row_excl;
    logic mul_done;
    logic is_cof;
    logic det_zero;
    logic div_done;
    logic out_free;
    logic pos_last;
  } status_t;

endpackage

// ----- rtl/matrix_inverse_adjugate.sv -----
// Top level of the adjugate matrix inverter.
// Depends on mia_pkg, mia_ctrl and mia_datapath.
//
// Usage: write the order k (1..MAX_ORDER) on cfg_wr_en/cfg_wr_data while the
// block is idle; a write also drops any partly loaded matrix. Stream the k*k
// Q8.8 elements in row-major order on the s_axis channel, one per cycle while
// s_axis_tready is high. After the last element the block computes the exact
// determinant and every cofactor by scanning all k^k column tuples of the
// expansion; each permutation term passes row by row through the serial
// multiplier, and any other tuple is skipped. Each inverse element then
// needs one cofactor scan over the k^(k-1) tuples of its minor plus a
// restoring division, one quotient bit per cycle. Results leave on
// m_axis in row-major order: tdata holds the Q16.16 inverse element and the
// Q40.24 determinant, tuser the singular flag, tlast the last result of the
// matrix. A singular matrix gives one result with tuser set. No element is
// taken while results are computed. A stalled receiver holds the output
// register and the computation waits on it. Reset sets the order to 4 and
// empties the load position and the output register.
`timescale 1ns / 1ps

module matrix_inverse_adjugate #(
  parameter int MAX_ORDER = mia_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mia_pkg::ORDER_W-1:0] cfg_wr_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // element [15:0]
  input  logic [15:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // inverse_value [31:0], determinant [95:32]
  output logic [95:0]                 m_axis_tdata,
  // singular [0]
  output logic [0:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  mia_pkg::cmd_t                cmd;
  mia_pkg::status_t             status;
  logic [mia_pkg::INV_W-1:0]    inv_out;
  logic [mia_pkg::DETQ_W-1:0]   det_out;
  logic                         sing_out;

  // Sequencer.
  mia_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Arithmetic and storage.
  mia_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .inv_out       (inv_out),
    .det_out       (det_out),
    .sing_out      (sing_out),
    .last_out      (m_axis_tlast),
    .cmd           (cmd),
    .status        (status)
  );

  // Port packing.
  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {det_out, inv_out};
  assign m_axis_tuser  = sing_out;

endmodule

// ----- rtl/mia_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mia_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mia_ctrl.sv -----
// Controller state machine of the adjugate matrix inverter.
// Depends on mia_pkg for the state type and the command and status bundles.
`timescale 1ns / 1ps

module mia_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  mia_pkg::status_t status,
  output mia_pkg::cmd_t    cmd
);

  mia_pkg::state_t state;
  mia_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mia_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mia_pkg::S_LOAD: begin
        if (status.load_done) state_next = mia_pkg::S_DET_INIT;
      end
      mia_pkg::S_DET_INIT: state_next = mia_pkg::S_TUPLE;
      mia_pkg::S_TUPLE: begin
        state_next = status.tuple_ok ? mia_pkg::S_FETCH : mia_pkg::S_NEXT;
      end
      mia_pkg::S_FETCH: begin
        if (status.row_end) begin
          state_next = mia_pkg::S_ACCUM;
        end else if (!status.row_excl) begin
          state_next = mia_pkg::S_MUL_LOAD;
        end
      end
      mia_pkg::S_MUL_LOAD: state_next = mia_pkg::S_MUL;
      mia_pkg::S_MUL: begin
        if (status.mul_done) state_next = mia_pkg::S_FETCH;
      end
      mia_pkg::S_ACCUM: state_next = mia_pkg::S_NEXT;
      mia_pkg::S_NEXT: begin
        state_next = status.enum_wrap ? mia_pkg::S_ENUM_DONE : mia_pkg::S_TUPLE;
      end
      mia_pkg::S_ENUM_DONE: begin
        state_next = status.is_cof ? mia_pkg::S_DIV : mia_pkg::S_DET_CHECK;
      end
      mia_pkg::S_DET_CHECK: begin
        state_next = status.det_zero ? mia_pkg::S_SING : mia_pkg::S_COF_INIT;
      end
      mia_pkg::S_COF_INIT: state_next = mia_pkg::S_TUPLE;
      mia_pkg::S_DIV: begin
        if (status.div_done) state_next = mia_pkg::S_EMIT;
      end
      mia_pkg::S_EMIT: begin
        if (status.out_free) begin
          state_next = status.pos_last ? mia_pkg::S_LOAD : mia_pkg::S_COF_INIT;
        end
      end
      mia_pkg::S_SING: begin
        if (status.out_free) state_next = mia_pkg::S_LOAD;
      end
      default: state_next = mia_pkg::S_LOAD;
    endcase
  end

  // Commands issued in each state.
  always_comb begin
    cmd = '0;
    case (state)
      mia_pkg::S_LOAD:     cmd.in_ready = 1'b1;
      mia_pkg::S_DET_INIT: cmd.enum_init = 1'b1;
      mia_pkg::S_TUPLE:    cmd.term_start = status.tuple_ok;
      mia_pkg::S_FETCH: begin
        cmd.row_step = !status.row_end && status.row_excl;
      end
      mia_pkg::S_MUL_LOAD: cmd.mul_load = 1'b1;
      mia_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.row_step = status.mul_done;
      end
      mia_pkg::S_ACCUM: cmd.accum = 1'b1;
      mia_pkg::S_NEXT:  cmd.enum_next = !status.enum_wrap;
      mia_pkg::S_ENUM_DONE: begin
        cmd.div_init  = status.is_cof;
        cmd.det_latch = !status.is_cof;
      end
      mia_pkg::S_DET_CHECK: cmd.det_quant = 1'b1;
      mia_pkg::S_COF_INIT: begin
        cmd.enum_init = 1'b1;
        cmd.enum_cof  = 1'b1;
      end
      mia_pkg::S_DIV: cmd.div_step = 1'b1;
      mia_pkg::S_EMIT: begin
        cmd.emit     = status.out_free;
        cmd.pos_next = status.out_free && !status.pos_last;
      end
      mia_pkg::S_SING: cmd.emit_sing = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/mia_datapath.sv -----
// Datapath of the adjugate matrix inverter: element store, permutation
// scan, serial multiplier, accumulator, serial divider and output register.
// Depends on mia_pkg and mia_ram.
`timescale 1ns / 1ps

module mia_datapath #(
  parameter int MAX_ORDER = mia_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mia_pkg::ORDER_W-1:0]  cfg_wr_data,
  input  logic                         s_axis_tvalid,
  input  logic [mia_pkg::ELEM_W-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mia_pkg::INV_W-1:0]    inv_out,
  output logic [mia_pkg::DETQ_W-1:0]   det_out,
  output logic                         sing_out,
  output logic                         last_out,
  input  mia_pkg::cmd_t                cmd,
  output mia_pkg::status_t             status
);

  localparam int EW    = mia_pkg::ELEM_W;
  localparam int RIW   = $clog2(MAX_ORDER);
  localparam int KW    = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = EW * MAX_ORDER + 8;
  localparam int PW    = (EW - 1) * MAX_ORDER + 1;
  localparam int NW    = DW + mia_pkg::DIV_SHIFT;
  localparam int RW    = DW + 1;
  localparam int CW    = $clog2(NW);
  localparam int TW    = DW + 17;
  localparam int MBW   = $clog2(EW);
  localparam int IW    = mia_pkg::INV_W;
  localparam int QW    = mia_pkg::DETQ_W;

  logic [mia_pkg::ORDER_W-1:0] order;
  logic [KW-1:0]               k;
  logic [RIW-1:0]              km1;
  logic [RIW-1:0]              load_row;
  logic [RIW-1:0]              load_col;
  logic                        in_acc;
  logic                        load_last;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [EW-1:0]               rdata;

  logic [RIW-1:0]              dig [MAX_ORDER];
  logic [RIW-1:0]              dig_next [MAX_ORDER];
  logic [MAX_ORDER-1:0]        incl;
  logic                        is_cof;
  logic                        tuple_ok;
  logic                        parity;
  logic                        wrap;

  logic [KW-1:0]               r;
  logic [RIW-1:0]              rsel;
  logic [PW-1:0]               prod;
  logic [PW-1:0]               mcand;
  logic [EW-1:0]               mbits;
  logic [MBW-1:0]              mcnt;
  logic                        term_neg;
  logic signed [DW-1:0]        acc;

  logic                        dneg;
  logic [DW-1:0]               dmag;
  logic [DW-1:0]               amag;
  logic [QW-1:0]               detq;
  logic [QW-1:0]               detq_calc;

  logic [RIW-1:0]              p;
  logic [RIW-1:0]              q;

  logic                        cneg;
  logic [NW-1:0]               nreg;
  logic [RW-1:0]               rem;
  logic [RW:0]                 rem_s;
  logic [RW:0]                 den;
  logic [CW-1:0]               dcnt;
  logic [IW-1:0]               inv_calc;

  // Effective order: zero counts as one, large values clamp to the maximum.
  always_comb begin
    if (order == '0) begin
      k = KW'(1);
    end else if (int'(order) > MAX_ORDER) begin
      k = KW'(MAX_ORDER);
    end else begin
      k = KW'(order);
    end
    km1 = RIW'(k - KW'(1));
  end

  // Order register and load position.
  assign in_acc    = cmd.in_ready && s_axis_tvalid;
  assign load_last = (load_row == km1) && (load_col == km1);

  always_ff @(posedge clk) begin
    if (rst) begin
      order    <= mia_pkg::ORDER_RESET;
      load_row <= '0;
      load_col <= '0;
    end else if (cfg_wr_en) begin
      order    <= cfg_wr_data;
      load_row <= '0;
      load_col <= '0;
    end else if (in_acc) begin
      if (load_col == km1) begin
        load_col <= '0;
        load_row <= (load_row == km1) ? '0 : load_row + RIW'(1);
      end else begin
        load_col <= load_col + RIW'(1);
      end
    end
  end

  // Element store, laid out with a row pitch of the maximum order.
  assign waddr = AW'(AW'(load_row) * AW'(MAX_ORDER) + AW'(load_col));
  assign rsel  = r[RIW-1:0];
  assign raddr = AW'(AW'(rsel) * AW'(MAX_ORDER) + AW'(dig[rsel]));

  mia_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (waddr),
    .wdata (s_axis_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Rows taking part in the current expansion; a cofactor drops row q.
  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      incl[i] = (i < int'(k)) && !(is_cof && (i == int'(q)));
    end
  end

  // Column tuple check: distinct columns, excluded column unused, and the
  // inversion parity that gives the sign of the permutation.
  always_comb begin
    tuple_ok = 1'b1;
    parity   = 1'b0;
    wrap     = 1'b1;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (incl[i]) begin
        if (is_cof && (dig[i] == p)) tuple_ok = 1'b0;
        if (dig[i] != km1) wrap = 1'b0;
        for (int j = i + 1; j < MAX_ORDER; j++) begin
          if (incl[j]) begin
            if (dig[i] == dig[j]) tuple_ok = 1'b0;
            if (dig[i] > dig[j]) parity = ~parity;
          end
        end
      end
    end
  end

  // Mixed-radix step of the column tuple over the included rows.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < MAX_ORDER; i++) begin
      dig_next[i] = dig[i];
      if (incl[i] && carry) begin
        if (dig[i] == km1) begin
          dig_next[i] = '0;
        end else begin
          dig_next[i] = dig[i] + RIW'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  // Scan, serial multiply and accumulate.
  always_ff @(posedge clk) begin
    if (cmd.enum_init) begin
      for (int i = 0; i < MAX_ORDER; i++) dig[i] <= '0;
      acc <= '0;
    end else if (cmd.enum_next) begin
      for (int i = 0; i < MAX_ORDER; i++) dig[i] <= dig_next[i];
    end else if (cmd.accum) begin
      acc <= term_neg ? acc - signed'(DW'(prod)) : acc + signed'(DW'(prod));
    end

    if (cmd.term_start) begin
      prod     <= PW'(1);
      term_neg <= parity ^ (is_cof & (p[0] ^ q[0]));
    end else if (cmd.mul_load) begin
      mcand    <= prod;
      prod     <= '0;
      mbits    <= rdata[EW-1] ? EW'(-rdata) : rdata;
      term_neg <= term_neg ^ rdata[EW-1];
      mcnt     <= MBW'(EW - 1);
    end else if (cmd.mul_step) begin
      prod  <= (prod << 1) + (mbits[EW-1] ? mcand : PW'(0));
      mbits <= mbits << 1;
      mcnt  <= mcnt - MBW'(1);
    end

    if (cmd.term_start) begin
      r <= '0;
    end else if (cmd.row_step) begin
      r <= r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_cof <= 1'b0;
    end else if (cmd.enum_init) begin
      is_cof <= cmd.enum_cof;
    end
  end

  // Magnitude of the accumulator.
  assign amag = acc[DW-1] ? DW'(-acc) : DW'(acc);

  // Determinant scaled to Q40.24: shift left for small orders, otherwise
  // shift right with rounding half away from zero, then saturate.
  always_comb begin
    int          sh;
    logic [TW-1:0] t;
    logic [QW-1:0] lim;
    sh = mia_pkg::ELEM_FRAC * int'(k) - mia_pkg::DETQ_FRAC;
    if (sh <= 0) begin
      t = TW'(dmag) << (-sh);
    end else begin
      t = ((TW'(dmag) >> (sh - 1)) + TW'(1)) >> 1;
    end
    lim = dneg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    if ((|t[TW-1:QW]) || (t[QW-1:0] > lim)) begin
      detq_calc = dneg ? QW'(-lim) : lim;
    end else begin
      detq_calc = dneg ? QW'(-t[QW-1:0]) : t[QW-1:0];
    end
  end

  // Determinant latch, output position and quantized determinant.
  always_ff @(posedge clk) begin
    if (cmd.det_latch) begin
      dneg <= acc[DW-1];
      dmag <= amag;
    end
    if (cmd.det_quant) begin
      detq <= detq_calc;
    end
    if (cmd.det_latch) begin
      p <= '0;
      q <= '0;
    end else if (cmd.pos_next) begin
      if (q == km1) begin
        q <= '0;
        p <= p + RIW'(1);
      end else begin
        q <= q + RIW'(1);
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign den   = (RW+1)'({dmag, 1'b0});
  assign rem_s = {rem, nreg[NW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      cneg <= acc[DW-1];
      nreg <= (NW'(amag) << mia_pkg::DIV_SHIFT) + NW'(dmag);
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_s >= den) begin
        rem  <= RW'(rem_s - den);
        nreg <= {nreg[NW-2:0], 1'b1};
      end else begin
        rem  <= RW'(rem_s);
        nreg <= {nreg[NW-2:0], 1'b0};
      end
      dcnt <= dcnt + CW'(1);
    end
  end

  // Saturate the quotient to Q16.16 with the sign of adj / det.
  always_comb begin
    logic          qneg;
    logic [IW-1:0] lim;
    qneg = cneg ^ dneg;
    lim  = qneg ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    if ((|nreg[NW-1:IW]) || (nreg[IW-1:0] > lim)) begin
      inv_calc = qneg ? IW'(-lim) : lim;
    end else begin
      inv_calc = qneg ? IW'(-nreg[IW-1:0]) : nreg[IW-1:0];
    end
  end

  // Output register; it can be refilled in the cycle it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit || cmd.emit_sing) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      inv_out  <= inv_calc;
      det_out  <= detq;
      sing_out <= 1'b0;
      last_out <= status.pos_last;
    end else if (cmd.emit_sing) begin
      inv_out  <= '0;
      det_out  <= '0;
      sing_out <= 1'b1;
      last_out <= 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    status           = '0;
    status.load_done = in_acc && load_last;
    status.tuple_ok  = tuple_ok;
    status.enum_wrap = wrap;
    status.row_end   = (r >= k);
    status.row_excl  = is_cof && (r == KW'(q));
    status.mul_done  = (mcnt == '0);
    status.is_cof    = is_cof;
    status.det_zero  = (dmag == '0);
    status.div_done  = (dcnt == CW'(NW - 1));
    status.out_free  = !m_axis_tvalid || m_axis_tready;
    status.pos_last  = (p == km1) && (q == km1);
  end

endmodule
